@@ sv/crc_checked_frame_deframer_assert.svh @@
`ifndef CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH
// implication check, disabled in reset
`define CFD_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("cfd check failed");
// next-cycle implication check
`define CFD_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("cfd check failed");
`endif

@@ sv/cfd_pkg.sv @@
package cfd_pkg;
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_MAXLEN = 2'd1;
    localparam logic [1:0] REG_HSEED = 2'd2;
    localparam logic [1:0] REG_FSEED = 2'd3;

    localparam logic [2:0] KIND_DATA = 3'd0;
    localparam logic [2:0] KIND_GOOD = 3'd1;
    localparam logic [2:0] KIND_HCRC = 3'd2;
    localparam logic [2:0] KIND_FCRC = 3'd3;
    localparam logic [2:0] KIND_LONG = 3'd4;
    localparam logic [2:0] KIND_TRUNC = 3'd5;

    localparam int QDEPTH = 2;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_CMDID   = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_TAIL    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] command_id;
        logic [7:0]  sequence_res;
        logic [9:0]  byte_index;
        logic [7:0]  payload_byte;
        logic [15:0] payload_length;
        logic        failed;
    } res_t;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++)
            v = v[0] ? ((v >> 1) ^ 8'h8C) : (v >> 1);
        return v;
    endfunction

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] v;
        v = {8'h00, crc[7:0] ^ b};
        for (int i = 0; i < 8; i++)
            v = v[0] ? ((v >> 1) ^ 16'h8408) : (v >> 1);
        return {8'h00, crc[15:8]} ^ v;
    endfunction
endpackage

@@ sv/cfd_front.sv @@
module cfd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              cmd,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        start_byte,
    input  logic [9:0]        max_payload_len,
    input  logic [7:0]        header_crc_seed,
    input  logic [15:0]       frame_crc_seed,
    output logic              push,
    output cfd_pkg::res_t     push_data
);
    import cfd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [9:0]  cnt_reg, cnt_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [7:0]  crc8_reg, crc8_next_v;
    logic [15:0] crc16_reg, crc16_next_v;
    logic [7:0]  tail_lo_reg, tail_lo_next;
    logic [15:0] crc16_upd;
    logic [9:0]  cnt_inc;
    res_t        r;

    assign crc16_upd = crc16_next(crc16_reg, rx_byte);
    assign cnt_inc = cnt_reg + 10'd1;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        len_next = len_reg;
        seq_next = seq_reg;
        cmd_next = cmd_reg;
        crc8_next_v = crc8_reg;
        crc16_next_v = crc16_reg;
        tail_lo_next = tail_lo_reg;
        push = 1'b0;
        r = '{kind: KIND_DATA, command_id: cmd_reg, sequence_res: seq_reg,
              byte_index: 10'd0, payload_byte: 8'd0, payload_length: len_reg,
              failed: 1'b0};
        if (in_valid) begin
            if (cmd) begin
                if (phase_reg != PH_HUNT) begin
                    push = 1'b1;
                    r.kind = KIND_TRUNC;
                    r.failed = 1'b1;
                    phase_next = PH_HUNT;
                    cnt_next = '0;
                end
            end else begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx_byte == start_byte) begin
                            crc8_next_v = crc8_next(header_crc_seed, rx_byte);
                            crc16_next_v = crc16_next(frame_crc_seed, rx_byte);
                            len_next = '0;
                            seq_next = '0;
                            cmd_next = '0;
                            tail_lo_next = '0;
                            cnt_next = '0;
                            phase_next = PH_HEADER;
                        end
                    end
                    PH_HEADER:
                    begin
                        crc16_next_v = crc16_upd;
                        if (cnt_reg < 10'd3) begin
                            crc8_next_v = crc8_next(crc8_reg, rx_byte);
                            if (cnt_reg == 10'd0)
                                len_next = {8'd0, rx_byte};
                            else if (cnt_reg == 10'd1)
                                len_next = {rx_byte, len_reg[7:0]};
                            else
                                seq_next = rx_byte;
                            cnt_next = cnt_inc;
                        end else if (rx_byte != crc8_reg) begin
                            push = 1'b1;
                            r.kind = KIND_HCRC;
                            r.failed = 1'b1;
                            phase_next = PH_HUNT;
                            cnt_next = '0;
                        end else if (len_reg > {6'd0, max_payload_len}) begin
                            push = 1'b1;
                            r.kind = KIND_LONG;
                            r.failed = 1'b1;
                            phase_next = PH_HUNT;
                            cnt_next = '0;
                        end else begin
                            phase_next = PH_CMDID;
                            cnt_next = '0;
                        end
                    end
                    PH_CMDID:
                    begin
                        crc16_next_v = crc16_upd;
                        if (cnt_reg == 10'd0) begin
                            cmd_next = {8'd0, rx_byte};
                            cnt_next = 10'd1;
                        end else begin
                            cmd_next = {rx_byte, cmd_reg[7:0]};
                            cnt_next = '0;
                            phase_next = (len_reg == 16'd0) ? PH_TAIL : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        crc16_next_v = crc16_upd;
                        push = 1'b1;
                        r.byte_index = cnt_reg;
                        r.payload_byte = rx_byte;
                        cnt_next = cnt_inc;
                        if ({6'd0, cnt_inc} >= len_reg || cnt_inc == 10'd0) begin
                            cnt_next = '0;
                            phase_next = PH_TAIL;
                        end
                    end
                    PH_TAIL:
                    begin
                        if (cnt_reg == 10'd0) begin
                            tail_lo_next = rx_byte;
                            cnt_next = 10'd1;
                        end else begin
                            push = 1'b1;
                            if ({rx_byte, tail_lo_reg} == crc16_reg) begin
                                r.kind = KIND_GOOD;
                            end else begin
                                r.kind = KIND_FCRC;
                                r.failed = 1'b1;
                            end
                            phase_next = PH_HUNT;
                            cnt_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                        cnt_next = '0;
                    end
                endcase
            end
        end
        push_data = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_HUNT;
            cnt_reg <= '0;
            len_reg <= '0;
            seq_reg <= '0;
            cmd_reg <= '0;
            crc8_reg <= 8'hFF;
            crc16_reg <= 16'hFFFF;
            tail_lo_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            len_reg <= len_next;
            seq_reg <= seq_next;
            cmd_reg <= cmd_next;
            crc8_reg <= crc8_next_v;
            crc16_reg <= crc16_next_v;
            tail_lo_reg <= tail_lo_next;
        end
    end
endmodule

@@ sv/cfd_back.sv @@
module cfd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfd_pkg::res_t push_data,
    output logic          space,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    kind,
    output logic [15:0]   command_id,
    output logic [7:0]    sequence_res,
    output logic [9:0]    byte_index,
    output logic [7:0]    payload_byte,
    output logic [15:0]   payload_length,
    output logic [15:0]   failure_count
);
    import cfd_pkg::*;

    res_t        q_reg [QDEPTH];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic [15:0] fail_reg;
    logic        pop;
    res_t        head;
    logic [15:0] fail_now;

    assign head = q_reg[rp_reg];
    assign out_valid = cnt_reg != 2'd0;
    assign pop = out_valid && out_ready;
    assign space = cnt_reg != 2'd2;

    // count fixed at dequeue, so the reported value includes this beat's failure
    assign fail_now = (head.failed && fail_reg != 16'hFFFF) ? fail_reg + 16'd1 : fail_reg;

    assign kind = head.kind;
    assign command_id = head.command_id;
    assign sequence_res = head.sequence_res;
    assign byte_index = head.byte_index;
    assign payload_byte = head.payload_byte;
    assign payload_length = head.payload_length;
    assign failure_count = fail_now;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
            fail_reg <= '0;
        end else begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop) begin
                rp_reg <= ~rp_reg;
                fail_reg <= fail_now;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ sv/crc_checked_frame_deframer.sv @@
// channel | direction | beat
// in      | input     | cmd, rx_byte on in_valid/in_ready
// cfg     | input     | cfg_index, cfg_data on cfg_valid/cfg_ready
// out     | output    | result fields on out_valid/out_ready
// One input beat per cycle while the result queue has space; an accepted beat's
// result is written into the result queue. The front stage updates the CRCs per byte.
// A two-entry result queue sits between front and back; input stalls only
// when it is full. Reset is asynchronous; config is always accepted.
module crc_checked_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [15:0] command_id,
    output logic [7:0]  sequence_res,
    output logic [9:0]  byte_index,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_length,
    output logic [15:0] failure_count
);
    import cfd_pkg::*;
    `include "crc_checked_frame_deframer_assert.svh"

    logic [7:0]  start_reg;
    logic [9:0]  maxlen_reg;
    logic [7:0]  hseed_reg;
    logic [15:0] fseed_reg;
    logic        space, push, acc;
    res_t        push_data;

    assign cfg_ready = 1'b1;
    assign in_ready = space;
    assign acc = in_valid && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_reg <= 8'hA5;
            maxlen_reg <= 10'd191;
            hseed_reg <= 8'hFF;
            fseed_reg <= 16'hFFFF;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_START:  start_reg <= cfg_data[7:0];
                REG_MAXLEN: maxlen_reg <= cfg_data[9:0];
                REG_HSEED:  hseed_reg <= cfg_data[7:0];
                REG_FSEED:  fseed_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cfd_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(acc), .cmd(cmd), .rx_byte(rx_byte),
        .start_byte(start_reg), .max_payload_len(maxlen_reg),
        .header_crc_seed(hseed_reg), .frame_crc_seed(fseed_reg),
        .push(push), .push_data(push_data)
    );

    cfd_back u_back (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .space(space),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
        .command_id(command_id), .sequence_res(sequence_res), .byte_index(byte_index),
        .payload_byte(payload_byte), .payload_length(payload_length),
        .failure_count(failure_count)
    );

    `CFD_ASSERT_IMP(a_push_has_room, push, space)
    `CFD_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid)
    `CFD_ASSERT_NEXT(a_push_shows, push, out_valid)
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import cfd_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct packed {
        logic       idle;
        logic [7:0] data;
    } rx_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] command_id;
        logic [7:0]  sequence_res;
        logic [9:0]  byte_index;
        logic [7:0]  payload_byte;
        logic [15:0] payload_length;
        logic [15:0] failure_count;
    } deframe_res_t;

    typedef enum logic [2:0] {
        ST_HUNT, ST_HEADER, ST_CMDID, ST_PAYLOAD, ST_TAIL
    } deframe_state_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [7:0]  rx_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [15:0] command_id;
    logic [7:0]  sequence_res;
    logic [9:0]  byte_index;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic [15:0] failure_count;

    crc_checked_frame_deframer u_top (.*);

    // predictor state
    logic [7:0]     m_start;
    logic [9:0]     m_maxlen;
    logic [7:0]     m_hseed;
    logic [15:0]    m_fseed;
    deframe_state_t m_state;
    logic [9:0]     m_cnt;
    logic [15:0]    m_len;
    logic [7:0]     m_seq;
    logic [15:0]    m_cmdid;
    logic [7:0]     m_crc8;
    logic [15:0]    m_crc16;
    logic [15:0]    m_tail;
    logic [15:0]    m_fails;

    rx_beat_t     pending_beats[$];
    deframe_res_t expected_results[$];
    int           errors;
    int           cycles;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           hold_send;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] crc8_step(logic [7:0] c, logic [7:0] b);
        logic [7:0] v;
        v = c ^ b;
        for (int i = 0; i < 8; i++)
            v = v[0] ? ((v >> 1) ^ 8'h8C) : (v >> 1);
        return v;
    endfunction

    function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] v;
        v = {8'h00, c[7:0] ^ b};
        for (int i = 0; i < 8; i++)
            v = v[0] ? ((v >> 1) ^ 16'h8408) : (v >> 1);
        return (c >> 8) ^ v;
    endfunction

    task automatic push_result(logic [2:0] k, logic [9:0] idx, logic [7:0] b);
        deframe_res_t r;
        r.kind = k;
        r.command_id = m_cmdid;
        r.sequence_res = m_seq;
        r.byte_index = idx;
        r.payload_byte = b;
        r.payload_length = m_len;
        r.failure_count = m_fails;
        expected_results.push_back(r);
    endtask

    task automatic close_frame(logic [2:0] k, bit failed);
        if (failed && m_fails != 16'hFFFF)
            m_fails++;
        push_result(k, 10'd0, 8'd0);
        m_state = ST_HUNT;
        m_cnt = '0;
    endtask

    task automatic deframe_step(rx_beat_t it);
        logic [7:0] b;
        b = it.data;
        if (it.idle) begin
            if (m_state != ST_HUNT)
                close_frame(KIND_TRUNC, 1'b1);
            return;
        end
        case (m_state)
            ST_HUNT:
                if (b == m_start) begin
                    m_crc8 = crc8_step(m_hseed, b);
                    m_crc16 = crc16_step(m_fseed, b);
                    m_len = '0;
                    m_seq = '0;
                    m_cmdid = '0;
                    m_tail = '0;
                    m_cnt = '0;
                    m_state = ST_HEADER;
                end
            ST_HEADER:
            begin
                m_crc16 = crc16_step(m_crc16, b);
                if (m_cnt < 3) begin
                    m_crc8 = crc8_step(m_crc8, b);
                    if (m_cnt == 0)
                        m_len = {8'h00, b};
                    else if (m_cnt == 1)
                        m_len[15:8] = b;
                    else
                        m_seq = b;
                    m_cnt++;
                end else if (b != m_crc8)
                    close_frame(KIND_HCRC, 1'b1);
                else if (m_len > {6'd0, m_maxlen})
                    close_frame(KIND_LONG, 1'b1);
                else begin
                    m_state = ST_CMDID;
                    m_cnt = '0;
                end
            end
            ST_CMDID:
            begin
                m_crc16 = crc16_step(m_crc16, b);
                if (m_cnt == 0) begin
                    m_cmdid = {8'h00, b};
                    m_cnt = 1;
                end else begin
                    m_cmdid[15:8] = b;
                    m_cnt = '0;
                    m_state = (m_len == 0) ? ST_TAIL : ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                m_crc16 = crc16_step(m_crc16, b);
                push_result(KIND_DATA, m_cnt, b);
                m_cnt++;
                if ({6'd0, m_cnt} >= m_len || m_cnt == 0) begin
                    m_cnt = '0;
                    m_state = ST_TAIL;
                end
            end
            default:
                if (m_cnt == 0) begin
                    m_tail = {8'h00, b};
                    m_cnt = 1;
                end else begin
                    m_tail[15:8] = b;
                    if (m_tail == m_crc16)
                        close_frame(KIND_GOOD, 1'b0);
                    else
                        close_frame(KIND_FCRC, 1'b1);
                end
        endcase
    endtask

    // frame builder, knobs pick which check the frame breaks
    task automatic queue_frame(int len, bit bad_hcrc, bit bad_fcrc, int cut_at);
        logic [7:0]  bytes[$];
        logic [7:0]  c8;
        logic [15:0] c16;
        rx_beat_t    it;
        bytes.push_back(m_start);
        bytes.push_back(len[7:0]);
        bytes.push_back(len[15:8]);
        bytes.push_back(8'($urandom_range(0, 255)));
        c8 = m_hseed;
        foreach (bytes[i])
            c8 = crc8_step(c8, bytes[i]);
        bytes.push_back(bad_hcrc ? ~c8 : c8);
        bytes.push_back(8'($urandom_range(0, 255)));
        bytes.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < len; i++)
            bytes.push_back(8'($urandom_range(0, 255)));
        c16 = m_fseed;
        foreach (bytes[i])
            c16 = crc16_step(c16, bytes[i]);
        if (bad_fcrc)
            c16 ^= 16'h1 << $urandom_range(0, 15);
        bytes.push_back(c16[7:0]);
        bytes.push_back(c16[15:8]);
        foreach (bytes[i])
        begin
            if (i == cut_at) begin
                it.idle = 1'b1;
                it.data = 8'($urandom_range(0, 255));
                pending_beats.push_back(it);
                break;
            end
            it.idle = 1'b0;
            it.data = bytes[i];
            pending_beats.push_back(it);
        end
    endtask

    task automatic queue_noise(int n);
        rx_beat_t it;
        for (int i = 0; i < n; i++)
        begin
            it.idle = ($urandom_range(0, 9) == 0);
            it.data = 8'($urandom_range(0, 255));
            pending_beats.push_back(it);
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_START:  m_start = val[7:0];
            REG_MAXLEN: m_maxlen = val[9:0];
            REG_HSEED:  m_hseed = val[7:0];
            default:    m_fseed = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // random mix: mostly well-formed frames, some broken, some noise;
    // too-long frames stop after the header byte with an idle beat
    task automatic random_phase(int n_frames);
        int r;
        for (int f = 0; f < n_frames; f++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                queue_frame($urandom_range(0, 12), 0, 0, -1);
            else if (r < 68)
                queue_frame($urandom_range(0, 12), 1, 0, -1);
            else if (r < 76)
                queue_frame($urandom_range(0, 12), 0, 1, -1);
            else if (r < 82)
                queue_frame(m_maxlen + $urandom_range(1, 3), 0, 0, 5);
            else if (r < 90)
                queue_frame($urandom_range(0, 12), 0, 0, $urandom_range(1, 14));
            else
                queue_noise($urandom_range(1, 6));
        end
        wait_drained();
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!in_valid || in_ready) begin
                if (pending_beats.size() != 0 && !hold_send
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    {cmd, rx_byte} <= pending_beats.pop_front();
                end else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        deframe_res_t want;
        if (rst_n) begin
            if (in_valid && in_ready)
                deframe_step({cmd, rx_byte});
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected kind", 16'(kind), 16'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (kind != want.kind)
                        report_mismatch("kind", 16'(kind), 16'(want.kind));
                    if (command_id != want.command_id)
                        report_mismatch("command_id", command_id, want.command_id);
                    if (sequence_res != want.sequence_res)
                        report_mismatch("sequence_res", 16'(sequence_res),
                                        16'(want.sequence_res));
                    if (byte_index != want.byte_index)
                        report_mismatch("byte_index", 16'(byte_index),
                                        16'(want.byte_index));
                    if (payload_byte != want.payload_byte)
                        report_mismatch("payload_byte", 16'(payload_byte),
                                        16'(want.payload_byte));
                    if (payload_length != want.payload_length)
                        report_mismatch("payload_length", payload_length,
                                        want.payload_length);
                    if (failure_count != want.failure_count)
                        report_mismatch("failure_count", failure_count,
                                        want.failure_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        rx_beat_t it;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = 1'b0;
        rx_byte = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_START;
        cfg_data = '0;
        out_ready = 1'b0;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_send = 1'b0;
        m_start = 8'hA5;
        m_maxlen = 10'd191;
        m_hseed = 8'hFF;
        m_fseed = 16'hFFFF;
        m_state = ST_HUNT;
        m_cnt = '0;
        m_len = '0;
        m_seq = '0;
        m_cmdid = '0;
        m_crc8 = 8'hFF;
        m_crc16 = 16'hFFFF;
        m_tail = '0;
        m_fails = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle while hunting, zero length, over-maximum length, each failure,
        // a start byte and one header byte left open, idle mid-frame
        it.idle = 1'b1;
        it.data = 8'h00;
        pending_beats.push_back(it);
        queue_frame(0, 0, 0, -1);
        queue_frame(1, 0, 0, -1);
        queue_frame(2, 1, 0, -1);
        queue_frame(2, 0, 1, -1);
        queue_frame(192, 0, 0, 5);
        queue_frame(3, 0, 0, 4);
        it.idle = 1'b0;
        it.data = 8'hA5;
        pending_beats.push_back(it);
        it.data = 8'hFF;
        pending_beats.push_back(it);
        wait_drained();

        // phase 1: no idling
        random_phase(10);

        // pause until everything has come out, then resume
        hold_send = 1'b1;
        wait_drained();
        hold_send = 1'b0;

        write_reg(REG_START, 16'h0000);
        write_reg(REG_MAXLEN, 16'd0);
        write_reg(REG_HSEED, 16'h0000);
        write_reg(REG_FSEED, 16'h0000);
        send_idle_pct = 68;
        random_phase(10);

        write_reg(REG_START, 16'h00FF);
        write_reg(REG_MAXLEN, 16'd1023);
        write_reg(REG_HSEED, 16'h005E);
        write_reg(REG_FSEED, 16'h1189);
        send_idle_pct = 0;
        recv_stall_pct = 68;
        random_phase(10);
        queue_frame(300, 0, 0, -1);
        wait_drained();

        write_reg(REG_MAXLEN, 16'd8);
        write_reg(REG_START, 16'h003C);
        send_idle_pct = 13;
        recv_stall_pct = 13;
        random_phase(10);

        write_reg(REG_START, 16'h00A5);
        write_reg(REG_MAXLEN, 16'd191);
        write_reg(REG_HSEED, 16'h00FF);
        write_reg(REG_FSEED, 16'hFFFF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(10);

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

@@ crc_checked_frame_deframer.f @@
+incdir+sv
sv/cfd_pkg.sv
sv/cfd_front.sv
sv/cfd_back.sv
sv/crc_checked_frame_deframer.sv
tb/tb.sv
